FILE: rtl/qrm_pkg.sv
// Shared types and constants for the quaternion to rotation matrix pipeline.
// No dependencies; used by every module of the block.
package qrm_pkg;

  localparam int FRAC_BITS_DEFAULT = 14;

  localparam int IN_W    = 16;  // quaternion component width
  localparam int OUT_W   = 16;  // matrix entry width
  localparam int NUM_ENT = 9;   // entries of the 3x3 matrix
  localparam int PROD_W  = 32;  // 16x16 product
  localparam int N_W     = 33;  // squared norm, and every numerator magnitude

  // Entry positions, row-major; also the lane order through the divider
  localparam int E_M00 = 0;
  localparam int E_M01 = 1;
  localparam int E_M02 = 2;
  localparam int E_M10 = 3;
  localparam int E_M11 = 4;
  localparam int E_M12 = 5;
  localparam int E_M20 = 6;
  localparam int E_M21 = 7;
  localparam int E_M22 = 8;

  // Operands for the divider: every lane magnitude is at most n
  typedef struct packed {
    logic [N_W-1:0]                n;
    logic [NUM_ENT-1:0][N_W-1:0]   mag;
    logic [NUM_ENT-1:0]            neg;
    logic                          zero;
  } div_in_t;

  // Fixed-point 1.0, clamped to the largest positive 16-bit value
  function automatic logic [OUT_W-1:0] one_pattern(input int frac_bits);
    longint unsigned lim;
    lim = 64'd1 << frac_bits;
    if (lim > 64'd32767) lim = 64'd32767;
    return OUT_W'(lim);
  endfunction

endpackage

FILE: rtl/qrm_products.sv
// Front end: component products, then squared norm and signed numerators.
// Depends on qrm_pkg. Two register stages.
module qrm_products (
  input  logic                              clk,
  input  logic [1:0]                        en,
  input  logic signed [qrm_pkg::IN_W-1:0]   quat_w,
  input  logic signed [qrm_pkg::IN_W-1:0]   quat_x,
  input  logic signed [qrm_pkg::IN_W-1:0]   quat_y,
  input  logic signed [qrm_pkg::IN_W-1:0]   quat_z,
  output qrm_pkg::div_in_t                  dout
);

  localparam int PW = qrm_pkg::PROD_W;
  localparam int NW = qrm_pkg::N_W;

  logic signed [PW-1:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  logic signed [PW-1:0] sq_w, sq_x, sq_y, sq_z, xy, wz, xz, wy, yz, wx;

  logic signed [NW:0] num [qrm_pkg::NUM_ENT];
  logic [NW-1:0]      n_next;
  qrm_pkg::div_in_t   dout_next;

  function automatic logic signed [NW:0] ext(input logic signed [PW-1:0] p);
    return {{(NW + 1 - PW){p[PW-1]}}, p};
  endfunction

  always_comb begin
    p_ww = quat_w * quat_w;
    p_xx = quat_x * quat_x;
    p_yy = quat_y * quat_y;
    p_zz = quat_z * quat_z;
    p_xy = quat_x * quat_y;
    p_wz = quat_w * quat_z;
    p_xz = quat_x * quat_z;
    p_wy = quat_w * quat_y;
    p_yz = quat_y * quat_z;
    p_wx = quat_w * quat_x;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_w <= p_ww;
      sq_x <= p_xx;
      sq_y <= p_yy;
      sq_z <= p_zz;
      xy   <= p_xy;
      wz   <= p_wz;
      xz   <= p_xz;
      wy   <= p_wy;
      yz   <= p_yz;
      wx   <= p_wx;
    end
  end

  // Off-diagonal numerators are doubled so every ratio is taken against n
  // with the same scale; |num| <= n holds for all nine lanes.
  always_comb begin
    n_next = NW'(ext(sq_w) + ext(sq_x) + ext(sq_y) + ext(sq_z));
    num[qrm_pkg::E_M00] = ext(sq_w) + ext(sq_x) - ext(sq_y) - ext(sq_z);
    num[qrm_pkg::E_M11] = ext(sq_w) - ext(sq_x) + ext(sq_y) - ext(sq_z);
    num[qrm_pkg::E_M22] = ext(sq_w) - ext(sq_x) - ext(sq_y) + ext(sq_z);
    num[qrm_pkg::E_M01] = (ext(xy) - ext(wz)) <<< 1;
    num[qrm_pkg::E_M10] = (ext(xy) + ext(wz)) <<< 1;
    num[qrm_pkg::E_M02] = (ext(xz) + ext(wy)) <<< 1;
    num[qrm_pkg::E_M20] = (ext(xz) - ext(wy)) <<< 1;
    num[qrm_pkg::E_M12] = (ext(yz) - ext(wx)) <<< 1;
    num[qrm_pkg::E_M21] = (ext(yz) + ext(wx)) <<< 1;
    dout_next.n    = n_next;
    dout_next.zero = (n_next == '0);
    for (int l = 0; l < qrm_pkg::NUM_ENT; l++) begin
      dout_next.neg[l] = num[l][NW];
      dout_next.mag[l] = num[l][NW] ? NW'(-num[l]) : NW'(num[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dout <= dout_next;
    end
  end

endmodule

FILE: rtl/qrm_divider.sv
// Nine-lane restoring divider, one quotient bit per register stage.
// Depends on qrm_pkg. Gives floor(mag * 2^(FRAC_BITS+1) / n) per lane.
module qrm_divider #(
  parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                             clk,
  input  logic [FRAC_BITS+1:0]                             en,
  input  qrm_pkg::div_in_t                                 din,
  output logic [qrm_pkg::NUM_ENT-1:0][FRAC_BITS+1:0]       quo,
  output logic [qrm_pkg::NUM_ENT-1:0]                      neg,
  output logic                                             zero
);

  localparam int STEPS = FRAC_BITS + 2;
  localparam int NW    = qrm_pkg::N_W;
  localparam int NE    = qrm_pkg::NUM_ENT;

  logic [NW-1:0]              n_q   [STEPS-1];
  logic [NE-1:0][NW-1:0]      rem_q [STEPS-1];
  logic [NE-1:0][STEPS-1:0]   quo_q [STEPS];
  logic [NE-1:0]              neg_q [STEPS];
  logic                       zero_q [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [NW-1:0]             n_in;
    logic [NE-1:0][NW:0]       cand;
    logic [NE-1:0][NW:0]       diff;
    logic [NE-1:0]             qbit;
    logic [NE-1:0][STEPS-1:0]  quo_in;
    logic [NE-1:0]             neg_in;
    logic                      zero_in;

    if (s == 0) begin : g_first
      // first bit: mag <= n, so the leading quotient bit is mag >= n
      always_comb begin
        n_in    = din.n;
        quo_in  = '0;
        neg_in  = din.neg;
        zero_in = din.zero;
        for (int l = 0; l < NE; l++) begin
          cand[l] = {1'b0, din.mag[l]};
        end
      end
    end else begin : g_next
      always_comb begin
        n_in    = n_q[s-1];
        quo_in  = quo_q[s-1];
        neg_in  = neg_q[s-1];
        zero_in = zero_q[s-1];
        for (int l = 0; l < NE; l++) begin
          cand[l] = {rem_q[s-1][l], 1'b0};
        end
      end
    end

    always_comb begin
      for (int l = 0; l < NE; l++) begin
        qbit[l] = (cand[l] >= {1'b0, n_in});
        diff[l] = cand[l] - {1'b0, n_in};
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        for (int l = 0; l < NE; l++) begin
          quo_q[s][l] <= {quo_in[l][STEPS-2:0], qbit[l]};
        end
        neg_q[s]  <= neg_in;
        zero_q[s] <= zero_in;
      end
    end

    if (s < STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[s]) begin
          n_q[s] <= n_in;
          for (int l = 0; l < NE; l++) begin
            rem_q[s][l] <= qbit[l] ? diff[l][NW-1:0] : cand[l][NW-1:0];
          end
        end
      end
    end
  end

  assign quo  = quo_q[STEPS-1];
  assign neg  = neg_q[STEPS-1];
  assign zero = zero_q[STEPS-1];

endmodule

FILE: rtl/qrm_round.sv
// Output stage: round half away from zero, saturate, apply sign, identity on zero norm.
// Depends on qrm_pkg. One register stage, which is the block's output register.
module qrm_round #(
  parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                                  clk,
  input  logic                                                  en,
  input  logic [qrm_pkg::NUM_ENT-1:0][FRAC_BITS+1:0]            quo,
  input  logic [qrm_pkg::NUM_ENT-1:0]                           neg,
  input  logic                                                  zero,
  output logic [qrm_pkg::NUM_ENT-1:0][qrm_pkg::OUT_W-1:0]       ent,
  output logic                                                  zero_norm
);

  localparam int STEPS = FRAC_BITS + 2;
  localparam int QW    = FRAC_BITS + 1;
  localparam int OW    = qrm_pkg::OUT_W;
  localparam int NE    = qrm_pkg::NUM_ENT;

  localparam longint unsigned LIM     = 64'd1 << FRAC_BITS;
  localparam longint unsigned POS_MAX = (LIM > 64'd32767) ? 64'd32767 : LIM;
  localparam longint unsigned NEG_MAX = (LIM > 64'd32768) ? 64'd32768 : LIM;
  localparam logic [OW-1:0]   ONE_PAT = qrm_pkg::one_pattern(FRAC_BITS);

  logic [NE-1:0][STEPS:0]  tp1;
  logic [NE-1:0][QW-1:0]   qv;
  logic [NE-1:0][OW:0]     mag;
  logic [NE-1:0][OW-1:0]   ent_next;

  always_comb begin
    for (int l = 0; l < NE; l++) begin
      // quotient carries one extra fraction bit: (t + 1) >> 1 rounds it
      tp1[l] = {1'b0, quo[l]} + (STEPS + 1)'(1);
      qv[l]  = tp1[l][QW:1];
      if (neg[l]) begin
        mag[l]      = (qv[l] > QW'(NEG_MAX)) ? (OW + 1)'(NEG_MAX) : (OW + 1)'(qv[l]);
        ent_next[l] = OW'((OW + 1)'(0) - mag[l]);
      end else begin
        mag[l]      = (qv[l] > QW'(POS_MAX)) ? (OW + 1)'(POS_MAX) : (OW + 1)'(qv[l]);
        ent_next[l] = mag[l][OW-1:0];
      end
      if (zero) begin
        if (l == qrm_pkg::E_M00 || l == qrm_pkg::E_M11 || l == qrm_pkg::E_M22) begin
          ent_next[l] = ONE_PAT;
        end else begin
          ent_next[l] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent       <= ent_next;
      zero_norm <= zero;
    end
  end

endmodule

FILE: rtl/quaternion_to_rotation_matrix_top.sv
// Top level of the quaternion to 3x3 rotation matrix converter.
// Depends on qrm_pkg, qrm_products, qrm_divider and qrm_round.
//
// Converts one Q2.14 quaternion (w, x, y, z) per transaction into the nine
// rotation matrix entries, normalized by the exact squared norm, rounded to
// nearest (ties away from zero) and saturated to +/-1.0. An all-zero
// quaternion yields the identity matrix with m_axis_tuser set. The block
// accepts one transaction every clock cycle unless output back-pressure has
// filled every stage; the restoring divider resolves one quotient bit per
// pipeline stage. Each stage advances when it is empty or its successor
// advances, so internal bubbles are squeezed out under back-pressure and
// the output register holds a result until it is taken.
module quaternion_to_rotation_matrix_top #(
  parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [143:0]  m_axis_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic          m_axis_tuser    // zero_norm
);

  localparam int STEPS = FRAC_BITS + 2;
  localparam int NSTG  = STEPS + 3;
  localparam int IW    = qrm_pkg::IN_W;
  localparam logic [qrm_pkg::OUT_W-1:0] ONE_PAT = qrm_pkg::one_pattern(FRAC_BITS);

  logic [NSTG-1:0] stg_valid;
  logic [NSTG-1:0] stg_en;

  qrm_pkg::div_in_t                                  div_in;
  logic [qrm_pkg::NUM_ENT-1:0][STEPS-1:0]            quo;
  logic [qrm_pkg::NUM_ENT-1:0]                       quo_neg;
  logic                                              quo_zero;
  logic [qrm_pkg::NUM_ENT-1:0][qrm_pkg::OUT_W-1:0]   ent;

  // stage i loads when it is empty or stage i+1 loads
  always_comb begin
    stg_en[NSTG-1] = !stg_valid[NSTG-1] || m_axis_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      stg_en[i] = !stg_valid[i] || stg_en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      if (stg_en[0]) begin
        stg_valid[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (stg_en[i]) begin
          stg_valid[i] <= stg_valid[i-1];
        end
      end
    end
  end

  assign s_axis_tready = stg_en[0];
  assign m_axis_tvalid = stg_valid[NSTG-1];

  qrm_products u_products (
    .clk    (clk),
    .en     (stg_en[1:0]),
    .quat_w ($signed(s_axis_tdata[IW-1:0])),
    .quat_x ($signed(s_axis_tdata[2*IW-1:IW])),
    .quat_y ($signed(s_axis_tdata[3*IW-1:2*IW])),
    .quat_z ($signed(s_axis_tdata[4*IW-1:3*IW])),
    .dout   (div_in)
  );

  qrm_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk  (clk),
    .en   (stg_en[STEPS+1:2]),
    .din  (div_in),
    .quo  (quo),
    .neg  (quo_neg),
    .zero (quo_zero)
  );

  qrm_round #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk       (clk),
    .en        (stg_en[NSTG-1]),
    .quo       (quo),
    .neg       (quo_neg),
    .zero      (quo_zero),
    .ent       (ent),
    .zero_norm (m_axis_tuser)
  );

  assign m_axis_tdata = ent;

  // input side only stalls when every stage is full and the output is held
  a_stall_only_when_full : assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while the pipeline has room");

  a_zero_norm_identity : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[15:0] == ONE_PAT && m_axis_tdata[79:64] == ONE_PAT &&
      m_axis_tdata[143:128] == ONE_PAT && m_axis_tdata[63:16] == '0 &&
      m_axis_tdata[127:80] == '0)
    else $error("zero-norm result is not the identity matrix");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for quaternion_to_rotation_matrix_top: exact integer predictor,
// in-order scoreboard, random pacing on both stream sides and one long output stall.
// Depends on qrm_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import qrm_pkg::*;

  localparam int FRAC        = FRAC_BITS_DEFAULT;
  localparam int PIPE_DEPTH  = FRAC + 5;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_ITEMS  = 1880;

  typedef struct packed {
    logic signed [IN_W-1:0] z;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] w;
  } quat_t;

  typedef struct packed {
    logic [NUM_ENT-1:0][OUT_W-1:0] ent;
    logic                          zero_norm;
  } rot_mat_t;

  class rot_scoreboard;
    rot_mat_t pending[$];
    int errors;
    int checked;
    int zero_seen;

    function logic [OUT_W-1:0] unity();
      longint unsigned lim;
      lim = 64'd1 << FRAC;
      if (lim > 64'd32767) lim = 64'd32767;
      return lim[OUT_W-1:0];
    endfunction

    // round(num * 2^shift / n), ties away from zero, clamped to +/-1.0 and 16 bits
    function logic [OUT_W-1:0] scaled_entry(longint num, int shift, longint unsigned n);
      bit neg;
      longint unsigned mag, q, lim;
      neg = num < 0;
      mag = neg ? -num : num;
      q = ((mag << shift) * 2 + n) / (2 * n);
      lim = 64'd1 << FRAC;
      if (q > lim) q = lim;
      if (!neg && q > 64'd32767) q = 64'd32767;
      if (neg && q > 64'd32768) q = 64'd32768;
      if (neg) q = -q;
      return q[OUT_W-1:0];
    endfunction

    function rot_mat_t predict_matrix(quat_t q);
      longint w, x, y, z, ww, xx, yy, zz;
      longint unsigned n;
      rot_mat_t r;
      w = q.w;
      x = q.x;
      y = q.y;
      z = q.z;
      ww = w * w;
      xx = x * x;
      yy = y * y;
      zz = z * z;
      n = ww + xx + yy + zz;
      r = '0;
      if (n == 0) begin
        r.ent[E_M00] = unity();
        r.ent[E_M11] = unity();
        r.ent[E_M22] = unity();
        r.zero_norm  = 1'b1;
        return r;
      end
      r.ent[E_M00] = scaled_entry(ww + xx - yy - zz, FRAC, n);
      r.ent[E_M01] = scaled_entry(x * y - w * z, FRAC + 1, n);
      r.ent[E_M02] = scaled_entry(x * z + w * y, FRAC + 1, n);
      r.ent[E_M10] = scaled_entry(x * y + w * z, FRAC + 1, n);
      r.ent[E_M11] = scaled_entry(ww - xx + yy - zz, FRAC, n);
      r.ent[E_M12] = scaled_entry(y * z - w * x, FRAC + 1, n);
      r.ent[E_M20] = scaled_entry(x * z - w * y, FRAC + 1, n);
      r.ent[E_M21] = scaled_entry(y * z + w * x, FRAC + 1, n);
      r.ent[E_M22] = scaled_entry(ww - xx - yy + zz, FRAC, n);
      return r;
    endfunction

    function void note_quat(quat_t q);
      pending.push_back(predict_matrix(q));
    endfunction

    task report(string what);
      if (errors < 20) $display("ERROR: %s", what);
      errors++;
    endtask

    task check_matrix(logic [NUM_ENT*OUT_W-1:0] data, logic flag);
      rot_mat_t exp_mat;
      if (pending.size() == 0) begin
        report($sformatf("matrix with no quaternion pending, tdata=%h", data));
        return;
      end
      exp_mat = pending.pop_front();
      checked++;
      if (exp_mat.zero_norm) zero_seen++;
      for (int i = 0; i < NUM_ENT; i++) begin
        if (data[i*OUT_W +: OUT_W] !== exp_mat.ent[i])
          report($sformatf("matrix %0d entry m%0d%0d: got %0d, expected %0d", checked,
                           i / 3, i % 3, $signed(data[i*OUT_W +: OUT_W]),
                           $signed(exp_mat.ent[i])));
      end
      if (flag !== exp_mat.zero_norm)
        report($sformatf("matrix %0d zero_norm: got %b, expected %b", checked, flag,
                         exp_mat.zero_norm));
    endtask
  endclass

  logic                       clk;
  logic                       rst;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [63:0]                s_axis_tdata = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [NUM_ENT*OUT_W-1:0]   m_axis_tdata;
  logic                       m_axis_tuser;

  rot_scoreboard rot_sb;
  int send_idle_pct = 12;
  int recv_idle_pct = 53;
  bit hold_req = 1'b0;
  int hold_left = 0;

  quaternion_to_rotation_matrix_top #(.FRAC_BITS(FRAC)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic quat_t mk_quat(int w, int x, int y, int z);
    quat_t q;
    q.w = w[IN_W-1:0];
    q.x = x[IN_W-1:0];
    q.y = y[IN_W-1:0];
    q.z = z[IN_W-1:0];
    return q;
  endfunction

  function automatic int pick_extreme();
    int vals[5] = '{-32768, 32767, 0, 16384, -16384};
    return vals[$urandom_range(4)];
  endfunction

  function automatic quat_t rand_quat();
    quat_t q;
    int mode;
    mode = $urandom_range(9);
    q = quat_t'({$urandom, $urandom});
    case (mode)
      3, 4, 5: q = mk_quat($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                           $urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
      6: q = mk_quat($urandom_range(8) - 4, $urandom_range(8) - 4,
                     $urandom_range(8) - 4, $urandom_range(8) - 4);
      7: begin
        // sparse: knock out components at random
        if ($urandom_range(1)) q.w = '0;
        if ($urandom_range(1)) q.x = '0;
        if ($urandom_range(1)) q.y = '0;
        if ($urandom_range(1)) q.z = '0;
      end
      8: q = mk_quat(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
      9: begin
        if ($urandom_range(1)) q = '0;
        else q = mk_quat($urandom_range(2) - 1, $urandom_range(2) - 1,
                         $urandom_range(2) - 1, $urandom_range(2) - 1);
      end
      default: ;
    endcase
    return q;
  endfunction

  task automatic send_quat(quat_t q);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= q;
    do @(posedge clk); while (!s_axis_tready);
    rot_sb.note_quat(q);
  endtask

  task automatic send_random(int count);
    repeat (count) send_quat(rand_quat());
  endtask

  // Output side: check each transaction, then pick the next tready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) rot_sb.check_matrix(m_axis_tdata, m_axis_tuser);
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles in which neither side moves a transaction
  initial begin
    int stall;
    stall = 0;
    @(negedge rst);
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall = 0;
      else stall++;
    end
    $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rot_sb = new();
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero norm, axis rotations, extremes, tiny norms
    send_quat(mk_quat(0, 0, 0, 0));
    send_quat(mk_quat(16384, 0, 0, 0));
    send_quat(mk_quat(-16384, 0, 0, 0));
    send_quat(mk_quat(0, 16384, 0, 0));
    send_quat(mk_quat(0, 0, 16384, 0));
    send_quat(mk_quat(0, 0, 0, 16384));
    send_quat(mk_quat(8192, 8192, 8192, 8192));
    send_quat(mk_quat(-8192, 8192, -8192, 8192));
    send_quat(mk_quat(-32768, -32768, -32768, -32768));
    send_quat(mk_quat(32767, 32767, 32767, 32767));
    send_quat(mk_quat(-32768, 32767, -32768, 32767));
    send_quat(mk_quat(32767, -32768, 0, 0));
    send_quat(mk_quat(0, 0, -32768, 32767));
    send_quat(mk_quat(1, 0, 0, 0));
    send_quat(mk_quat(0, 0, 0, -1));
    send_quat(mk_quat(1, 1, 0, 0));
    send_quat(mk_quat(1, 1, 1, 0));
    send_quat(mk_quat(-1, -1, -1, -1));
    send_quat(mk_quat(0, 0, 0, 0));
    send_quat(mk_quat(11585, 0, 11585, 0));

    send_random(RAND_ITEMS / 3);

    send_idle_pct = 53;
    recv_idle_pct = 12;
    send_random(RAND_ITEMS / 3);

    // full rate, starting with a long output stall so the pipeline backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    send_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3));
    s_axis_tvalid <= 1'b0;

    while (rot_sb.pending.size() > 0) @(posedge clk);
    repeat (PIPE_DEPTH + 20) @(posedge clk);

    $display("Summary: %0d matrices checked (%0d zero-norm), three pacing phases,",
             rot_sb.checked, rot_sb.zero_seen);
    $display("         one %0d-cycle output stall with input back-pressure; %0d errors",
             HOLD_CYCLES, rot_sb.errors);
    if (rot_sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: quaternion_to_rotation_matrix_top.f
rtl/qrm_pkg.sv
rtl/qrm_products.sv
rtl/qrm_divider.sv
rtl/qrm_round.sv
rtl/quaternion_to_rotation_matrix_top.sv
tb/sv/testbench.sv
